@@ rtl/core/rstri_pkg.sv @@
`default_nettype none
package rstri_pkg;

  localparam int CNT_W = 5;
  localparam int CNT_MIN = 3;

  localparam logic RING_CURR = 1'b0;
  localparam logic RING_PREV = 1'b1;

  typedef struct packed {
    logic             ring;
    logic [CNT_W-1:0] index;
    logic             wrap;
  } corner_t;

  typedef struct packed {
    corner_t c0;
    corner_t c1;
    corner_t c2;
    logic    last;
  } tri_t;

  // one stitch job after clamping; big >= small, swap set when prev ring is larger
  typedef struct packed {
    logic [CNT_W-1:0] big;
    logic [CNT_W-1:0] small_n;
    logic             swap;
    logic             equal;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/core/ring_stitch_triangulator.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | curr_count, prev_count
// out     | output    | out_valid / out_stall | c0..c2 ring/index/wrap, last_triangle
//
// Equal counts: a start state, then one triangle per cycle while the output does not stall.
// Unequal counts: a start state, quotient by repeated subtraction, table fill, gap division
// and leftover spread when there are leftovers, then one triangle per cycle while the output
// does not stall, plus a table read for each smaller-ring vertex after vertex 0.
// A two-entry job queue lets new items land while a stitch runs.
// Reset is synchronous; a stall on the output holds the sequencer in its triangle states.
`default_nettype none
module ring_stitch_triangulator import rstri_pkg::*; #(
  parameter int MAX_RING_POINTS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CNT_W-1:0] curr_count,
  input  wire logic [CNT_W-1:0] prev_count,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  c0_ring,
  output logic [CNT_W-1:0]      c0_index,
  output logic                  c0_wrap,
  output logic                  c1_ring,
  output logic [CNT_W-1:0]      c1_index,
  output logic                  c1_wrap,
  output logic                  c2_ring,
  output logic [CNT_W-1:0]      c2_index,
  output logic                  c2_wrap,
  output logic                  last_triangle
);

  logic job_valid, job_pop;
  job_t job;
  tri_t out_tri;

  rstri_front #(.MAX_RING_POINTS(MAX_RING_POINTS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .curr_count, .prev_count,
    .job_valid, .job, .job_pop
  );

  rstri_back #(.MAX_RING_POINTS(MAX_RING_POINTS)) u_back (
    .clk, .rst, .job_valid, .job, .job_pop, .out_valid, .out_stall, .out_tri
  );

  assign c0_ring       = out_tri.c0.ring;
  assign c0_index      = out_tri.c0.index;
  assign c0_wrap       = out_tri.c0.wrap;
  assign c1_ring       = out_tri.c1.ring;
  assign c1_index      = out_tri.c1.index;
  assign c1_wrap       = out_tri.c1.wrap;
  assign c2_ring       = out_tri.c2.ring;
  assign c2_index      = out_tri.c2.index;
  assign c2_wrap       = out_tri.c2.wrap;
  assign last_triangle = out_tri.last;

endmodule
`default_nettype wire

@@ rtl/core/rstri_front.sv @@
`default_nettype none
module rstri_front import rstri_pkg::*; #(
  parameter int MAX_RING_POINTS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CNT_W-1:0] curr_count,
  input  wire logic [CNT_W-1:0] prev_count,
  output logic                  job_valid,
  output job_t                  job,
  input  wire logic             job_pop
);

  localparam logic [CNT_W-1:0] CMAX = CNT_W'(MAX_RING_POINTS);
  localparam logic [CNT_W-1:0] CMIN = CNT_W'(CNT_MIN);

  logic [CNT_W-1:0] c_cl, p_cl;
  job_t             job_in;
  job_t             q [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push;

  function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] v);
    if (v < CMIN) return CMIN;
    else if (v > CMAX) return CMAX;
    else return v;
  endfunction

  always_comb begin
    c_cl = clamp(curr_count);
    p_cl = clamp(prev_count);
    job_in.swap    = (c_cl < p_cl);
    job_in.equal   = (c_cl == p_cl);
    job_in.big     = job_in.swap ? p_cl : c_cl;
    job_in.small_n = job_in.swap ? c_cl : p_cl;
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (job_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= job_in;
  end

endmodule
`default_nettype wire

@@ rtl/core/rstri_back.sv @@
`default_nettype none
module rstri_back import rstri_pkg::*; #(
  parameter int MAX_RING_POINTS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output tri_t      out_tri
);

  localparam int AW = (MAX_RING_POINTS > 1) ? $clog2(MAX_RING_POINTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV_Q, S_FILL, S_DIV_G, S_LEFT, S_SEAM, S_FAN, S_PRE_FIRST, S_PRE,
    S_POST, S_PT_LOAD, S_PT_FIRST, S_PT_REST, S_EQ_A, S_EQ_B, S_EQ_S0, S_EQ_S1
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] big, small_n, q, left0, leftcnt, gap, rem, quo;
  logic [CNT_W-1:0] pt, cur, post, shr, remain;
  logic [3:0]       pre;
  logic [CNT_W:0]   i;
  logic             swap, sr, br;
  logic [CNT_W-1:0] mem [MAX_RING_POINTS];

  logic             emit, fire;
  tri_t             t;
  logic             lt_active, lt_bump;
  logic [CNT_W:0]   i1;
  logic [2*CNT_W-1:0] prod_a, prod_b;
  logic [CNT_W-1:0] s0, pre_v, post_v;

  assign sr = !swap;
  assign br = swap;
  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    prod_a    = (small_n - i[CNT_W-1:0]) * left0;
    prod_b    = small_n * leftcnt;
    lt_active = (i < {1'b0, small_n}) && (leftcnt != '0);
    lt_bump   = prod_a > prod_b;
    i1        = i + (CNT_W+1)'(lt_bump);
    // vertex 0 always takes one leftover point when there are any
    s0        = q + CNT_W'(left0 != '0);
    if (s0 <= CNT_W'(3)) begin
      pre_v  = '0;
      post_v = (s0 == CNT_W'(1)) ? '0 : s0 - CNT_W'(1);
    end else if (!s0[0]) begin
      pre_v  = s0 >> 1;
      post_v = s0 >> 1;
    end else begin
      pre_v  = s0 >> 1;
      post_v = (s0 >> 1) + CNT_W'(1);
    end
  end

  function automatic corner_t cn(input logic r, input logic [CNT_W-1:0] idx, input logic w);
    corner_t c;
    c.ring = r; c.index = idx; c.wrap = w;
    return c;
  endfunction

  always_comb begin
    emit = 1'b1;
    t    = '0;
    unique case (state)
      S_SEAM: begin
        t.c0 = cn(sr, '0, 1'b1); t.c1 = cn(br, '0, 1'b1);
        t.c2 = cn(br, big - CNT_W'(1), 1'b0);
      end
      S_FAN: begin
        t.c0 = cn(sr, '0, 1'b1); t.c1 = cn(br, big - CNT_W'(1), 1'b0);
        t.c2 = cn(sr, small_n - CNT_W'(1), 1'b0);
      end
      S_PRE_FIRST: begin
        t.c0 = cn(sr, '0, 1'b1); t.c1 = cn(br, big - CNT_W'(pre), 1'b0);
        t.c2 = cn(sr, small_n - CNT_W'(1), 1'b0);
      end
      S_PRE: begin
        t.c0 = cn(sr, '0, 1'b1); t.c1 = cn(br, big - CNT_W'(pre), 1'b0);
        t.c2 = cn(br, big - CNT_W'(pre) - CNT_W'(1), 1'b0);
      end
      S_POST: begin
        t.c0 = cn(sr, '0, 1'b0); t.c1 = cn(br, post, 1'b0);
        t.c2 = cn(br, post - CNT_W'(1), 1'b0);
      end
      S_PT_FIRST: begin
        t.c0 = cn(sr, pt, 1'b0); t.c1 = cn(br, cur, 1'b0);
        t.c2 = cn(sr, pt - CNT_W'(1), 1'b0);
      end
      S_PT_REST: begin
        t.c0 = cn(sr, pt, 1'b0); t.c1 = cn(br, cur, 1'b0);
        t.c2 = cn(br, cur - CNT_W'(1), 1'b0);
        t.last = (remain == CNT_W'(1)) && (pt == small_n - CNT_W'(1));
      end
      S_EQ_A: begin
        t.c0 = cn(RING_CURR, pt - CNT_W'(1), 1'b0);
        t.c1 = cn(RING_PREV, pt - CNT_W'(1), 1'b0);
        t.c2 = cn(RING_CURR, pt, 1'b0);
      end
      S_EQ_B: begin
        t.c0 = cn(RING_CURR, pt, 1'b0);
        t.c1 = cn(RING_PREV, pt - CNT_W'(1), 1'b0);
        t.c2 = cn(RING_PREV, pt, 1'b0);
      end
      S_EQ_S0: begin
        t.c0 = cn(RING_CURR, '0, 1'b1);
        t.c1 = cn(RING_CURR, big - CNT_W'(1), 1'b0);
        t.c2 = cn(RING_PREV, '0, 1'b1);
      end
      S_EQ_S1: begin
        t.c0 = cn(RING_CURR, big - CNT_W'(1), 1'b0);
        t.c1 = cn(RING_PREV, big - CNT_W'(1), 1'b0);
        t.c2 = cn(RING_PREV, '0, 1'b1);
        t.last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
    // the larger previous ring reverses winding: trade corners 1 and 2
    if (swap && !(state == S_EQ_A || state == S_EQ_B || state == S_EQ_S0 ||
                  state == S_EQ_S1)) begin
      t.c1 = t.c2;
      t.c2 = (state == S_SEAM) ? cn(br, '0, 1'b1) :
             (state == S_FAN || state == S_PRE_FIRST) ? cn(br,
               (state == S_FAN) ? big - CNT_W'(1) : big - CNT_W'(pre), 1'b0) :
             (state == S_PRE) ? cn(br, big - CNT_W'(pre), 1'b0) :
             (state == S_POST) ? cn(br, post, 1'b0) : cn(br, cur, 1'b0);
    end
  end

  assign fire = emit && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_tri <= t;
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL) mem[i[AW-1:0]] <= q;
    else if (state == S_LEFT && lt_active && i1 < {1'b0, small_n})
      mem[i1[AW-1:0]] <= q + CNT_W'(1);
    if (state == S_PT_LOAD) shr <= mem[pt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          big <= job.big; small_n <= job.small_n; swap <= job.swap;
          pt  <= CNT_W'(1);
          rem <= job.big; quo <= '0;
          state <= job.equal ? S_EQ_A : S_DIV_Q;
        end
        S_DIV_Q: begin
          if (rem >= small_n) begin
            rem <= rem - small_n; quo <= quo + CNT_W'(1);
          end else begin
            q <= quo; left0 <= rem; leftcnt <= rem;
            i <= '0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          i <= i + (CNT_W+1)'(1);
          if (i[CNT_W-1:0] == small_n - CNT_W'(1)) begin
            rem <= small_n; quo <= '0;
            state <= (left0 != '0) ? S_DIV_G : S_SEAM;
          end
        end
        S_DIV_G: begin
          if (rem >= left0) begin
            rem <= rem - left0; quo <= quo + CNT_W'(1);
          end else begin
            gap <= quo; i <= '0;
            state <= S_LEFT;
          end
        end
        S_LEFT: begin
          if (lt_active) begin
            i <= i1 + {1'b0, gap};
            leftcnt <= leftcnt - CNT_W'(1);
          end else begin
            state <= S_SEAM;
          end
        end
        S_SEAM: if (fire) begin
          pre <= pre_v[3:0]; post <= post_v; cur <= post_v;
          if (s0 <= CNT_W'(3)) state <= S_FAN;
          else state <= S_PRE_FIRST;
        end
        S_FAN: if (fire) state <= (post != '0) ? S_POST : S_PT_LOAD;
        S_PRE_FIRST, S_PRE: if (fire) begin
          pre <= pre - 4'd1;
          if (pre == 4'd1) state <= (post != '0) ? S_POST : S_PT_LOAD;
          else state <= S_PRE;
        end
        S_POST: if (fire) begin
          post <= post - CNT_W'(1);
          if (post == CNT_W'(1)) state <= S_PT_LOAD;
        end
        S_PT_LOAD: state <= S_PT_FIRST;
        S_PT_FIRST: if (fire) begin
          cur <= cur + CNT_W'(1); remain <= shr;
          state <= S_PT_REST;
        end
        S_PT_REST: if (fire) begin
          remain <= remain - CNT_W'(1);
          if (remain == CNT_W'(1)) begin
            if (pt == small_n - CNT_W'(1)) state <= S_IDLE;
            else begin
              pt <= pt + CNT_W'(1);
              state <= S_PT_LOAD;
            end
          end else begin
            cur <= cur + CNT_W'(1);
          end
        end
        S_EQ_A: if (fire) state <= S_EQ_B;
        S_EQ_B: if (fire) begin
          pt <= pt + CNT_W'(1);
          state <= (pt == big - CNT_W'(1)) ? S_EQ_S0 : S_EQ_A;
        end
        S_EQ_S0: if (fire) state <= S_EQ_S1;
        S_EQ_S1: if (fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rstri_checker.sv @@
`default_nettype none
module rstri_checker import rstri_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [CNT_W-1:0] c0_index,
  input wire logic [CNT_W-1:0] c1_index,
  input wire logic [CNT_W-1:0] c2_index,
  input wire logic             last_triangle
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(c0_index) && $stable(last_triangle))
    else $error("stalled item changed");

  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> c0_index <= 5'd23 && c1_index <= 5'd23 && c2_index <= 5'd23)
    else $error("corner index past ring");

  // every stitch opens at vertex 0 of its first corner's ring
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_triangle ##1 out_valid |-> c0_index == '0)
    else $error("stitch did not open at vertex 0");

endmodule

bind ring_stitch_triangulator rstri_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .c0_index, .c1_index, .c2_index,
  .last_triangle
);
`default_nettype wire
